// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pip_pkg.sv =====
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int HELD_W       = 5;
  localparam int OP_W         = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Vertex store access: one address, write or registered read.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
  } vmem_req_t;

endpackage
`default_nettype wire

// ===== sv/pip_vertex_mem.sv =====
`default_nettype none
module pip_vertex_mem (
  input  logic               clk,
  input  pip_pkg::vmem_req_t req,
  input  pip_pkg::coord_t    wr_x,
  input  pip_pkg::coord_t    wr_y,
  output pip_pkg::coord_t    rd_x,
  output pip_pkg::coord_t    rd_y
);

  pip_pkg::coord_t mem_x [pip_pkg::MAX_VERTICES];
  pip_pkg::coord_t mem_y [pip_pkg::MAX_VERTICES];
  pip_pkg::coord_t rd_x_r;
  pip_pkg::coord_t rd_y_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_x[req.addr] <= wr_x;
      mem_y[req.addr] <= wr_y;
    end
    if (req.re) begin
      rd_x_r <= mem_x[req.addr];
      rd_y_r <= mem_y[req.addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule
`default_nettype wire

// ===== sv/point_in_polygon_test.sv =====
`default_nettype none
// Point-in-polygon test by crossing count over a stored polygon.
// Input channel (in_valid/in_ready) carries an operation and a coordinate:
// clear empties the vertex store, append adds a vertex (dropped with
// out_status set when the store is full), query tests the point.
// Each input transaction yields exactly one result transaction on
// out_valid/out_ready with inside flag, status and current vertex count.
// Clear, append and unused codes: result valid in the cycle after accept.
// Query over n vertices: one vertex-store read to fetch the closing vertex,
// then the states MUL1, MUL2 and CMP for each edge on a single 17x17
// multiplier (two products and a compare). An empty polygon answers like a
// clear, with no store read. Only one transaction is in flight; in_ready is
// high when the sequencer is idle and the result register is empty or being
// taken in that cycle. A stalled receiver holds the result and blocks new
// input. Reset empties the polygon and drops any pending result.
module point_in_polygon_test (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pip_pkg::OP_W-1:0]     in_operation,
  input  pip_pkg::coord_t              in_coord_x,
  input  pip_pkg::coord_t              in_coord_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res,
  output logic                         out_status,
  output logic [pip_pkg::HELD_W-1:0]   out_vertices_held
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADJ = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]                  state_r;
  logic [pip_pkg::CNT_W-1:0]   count_r;
  logic [pip_pkg::IDX_W-1:0]   idx_r;
  logic                        last_r;
  logic                        out_valid_r;
  logic                        out_inside_r;
  logic                        out_status_r;
  logic                        inside_r;
  logic                        span_r;
  logic                        dypos_r;
  pip_pkg::coord_t             px_r, py_r, xj_r, yj_r;
  pip_pkg::prod_t              lhs_r, rhs_r;

  pip_pkg::vmem_req_t          mreq;
  pip_pkg::coord_t             rd_x, rd_y;
  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        is_last;
  logic                        left;
  logic [pip_pkg::CNT_W-1:0]   cnt_m1;
  logic [pip_pkg::IDX_W-1:0]   last_idx;
  pip_pkg::diff_t              mul_a, mul_b;
  pip_pkg::prod_t              mul_p;
  logic                        span;

  function automatic pip_pkg::diff_t sub_ext(input pip_pkg::coord_t a,
                                             input pip_pkg::coord_t b);
    pip_pkg::diff_t ae, be;
    ae = pip_pkg::DIFF_W'(a);
    be = pip_pkg::DIFF_W'(b);
    return ae - be;
  endfunction

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));
  assign empty     = (count_r == '0);
  assign cnt_m1    = count_r - pip_pkg::CNT_W'(1);
  assign last_idx  = cnt_m1[pip_pkg::IDX_W-1:0];
  assign is_last   = (idx_r == last_idx);

  always_comb begin
    mreq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_operation == pip_pkg::OP_APPEND && !full) begin
          mreq.we   = 1'b1;
          mreq.addr = count_r[pip_pkg::IDX_W-1:0];
        end else if (accept && in_operation == pip_pkg::OP_QUERY && !empty) begin
          mreq.re   = 1'b1;
          mreq.addr = last_idx;
        end
      end
      S_LOADJ: begin
        mreq.re   = 1'b1;
        mreq.addr = idx_r;
      end
      S_MUL2: begin
        mreq.re   = !is_last;
        mreq.addr = idx_r + pip_pkg::IDX_W'(1);
      end
      default: ;
    endcase
  end

  pip_vertex_mem u_mem (
    .clk  (clk),
    .req  (mreq),
    .wr_x (in_coord_x),
    .wr_y (in_coord_y),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  // Shared multiplier: (px-xi)*dy first, then (xj-xi)*(py-yi).
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = sub_ext(px_r, rd_x);
      mul_b = sub_ext(yj_r, rd_y);
    end else begin
      mul_a = sub_ext(xj_r, rd_x);
      mul_b = sub_ext(py_r, rd_y);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign span = ((rd_y <= py_r) && (py_r < yj_r)) || ((yj_r <= py_r) && (py_r < rd_y));
  // Sense of the cross-multiplied compare flips with the sign of dy.
  assign left = dypos_r ? (lhs_r < rhs_r) : (rhs_r < lhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_operation == pip_pkg::OP_QUERY && !empty) begin
              state_r     <= S_LOADJ;
              out_valid_r <= 1'b0;
            end else begin
              out_valid_r <= 1'b1;
              if (in_operation == pip_pkg::OP_CLEAR) begin
                count_r <= '0;
              end else if (in_operation == pip_pkg::OP_APPEND && !full) begin
                count_r <= count_r + pip_pkg::CNT_W'(1);
              end
            end
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_LOADJ: state_r <= S_MUL1;
        S_MUL1:  state_r <= S_MUL2;
        S_MUL2:  state_r <= S_CMP;
        S_CMP: begin
          if (last_r) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_MUL1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          px_r         <= in_coord_x;
          py_r         <= in_coord_y;
          idx_r        <= '0;
          inside_r     <= 1'b0;
          out_inside_r <= 1'b0;
          out_status_r <= (in_operation == pip_pkg::OP_APPEND) && full;
        end
      end
      S_LOADJ: begin
        xj_r <= rd_x;
        yj_r <= rd_y;
      end
      S_MUL1: begin
        lhs_r   <= mul_p;
        span_r  <= span;
        dypos_r <= (yj_r > rd_y);
      end
      S_MUL2: begin
        rhs_r  <= mul_p;
        xj_r   <= rd_x;
        yj_r   <= rd_y;
        last_r <= is_last;
        if (!is_last) begin
          idx_r <= idx_r + pip_pkg::IDX_W'(1);
        end
      end
      S_CMP: begin
        inside_r     <= inside_r ^ (span_r && left);
        out_inside_r <= inside_r ^ (span_r && left);
        out_status_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_inside_res    = out_inside_r;
  assign out_status        = out_status_r;
  assign out_vertices_held = pip_pkg::HELD_W'(count_r);

endmodule
`default_nettype wire

// ===== sv/pip_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pip_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [pip_pkg::OP_W-1:0]    in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_inside_res,
  input logic                        out_status,
  input logic [pip_pkg::HELD_W-1:0]  out_vertices_held
);

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_inside_res) && $stable(out_status) && $stable(out_vertices_held))
  `ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
  `ASSERT_IMP(a_drop_when_full, clk, rst_n, out_valid && out_status, !out_inside_res && out_vertices_held == pip_pkg::HELD_W'(pip_pkg::MAX_VERTICES))
  `ASSERT_NXT(a_clear_empties, clk, rst_n, in_valid && in_ready && in_operation == pip_pkg::OP_CLEAR, out_valid && out_vertices_held == '0 && !out_inside_res && !out_status)
  `ASSERT_IMP(a_held_range, clk, rst_n, out_valid, out_vertices_held <= pip_pkg::HELD_W'(pip_pkg::MAX_VERTICES))

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
`default_nettype wire

// ===== verif/point_in_polygon_test_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module point_in_polygon_test_tb;

  localparam logic [pip_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int QUIET_AFTER  = 1420;
  localparam int DRAIN_CYCLES = 3 * pip_pkg::MAX_VERTICES + 12;

  typedef struct packed {
    logic                       in_poly;
    logic                       status;
    logic [pip_pkg::HELD_W-1:0] held;
  } answer_t;

  class polygon_scoreboard;
    pip_pkg::coord_t vert_x[pip_pkg::MAX_VERTICES];
    pip_pkg::coord_t vert_y[pip_pkg::MAX_VERTICES];
    int unsigned     vert_count;
    answer_t         pending_answers[$];
    int              mismatches;

    function new();
      vert_count = 0;
      mismatches = 0;
    endfunction

    // crossing-number rule; products compared exactly in 64 bits
    function bit point_inside(pip_pkg::coord_t px, pip_pkg::coord_t py);
      bit     flag;
      int     j;
      longint x, y, xi, yi, xj, yj, dy, lhs, rhs;
      flag = 1'b0;
      x = px;
      y = py;
      if (vert_count == 0) return 1'b0;
      j = vert_count - 1;
      for (int i = 0; i < vert_count; i++) begin
        xi = vert_x[i];
        yi = vert_y[i];
        xj = vert_x[j];
        yj = vert_y[j];
        if (((yi <= y) && (y < yj)) || ((yj <= y) && (y < yi))) begin
          dy  = yj - yi;
          lhs = (x - xi) * dy;
          rhs = (xj - xi) * (y - yi);
          if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) flag = !flag;
        end
        j = i;
      end
      return flag;
    endfunction

    function void note_input(logic [pip_pkg::OP_W-1:0] op, pip_pkg::coord_t x,
                             pip_pkg::coord_t y);
      answer_t ans;
      ans.in_poly = 1'b0;
      ans.status  = 1'b0;
      case (op)
        pip_pkg::OP_CLEAR: vert_count = 0;
        pip_pkg::OP_APPEND: begin
          if (vert_count < pip_pkg::MAX_VERTICES) begin
            vert_x[vert_count] = x;
            vert_y[vert_count] = y;
            vert_count++;
          end else begin
            ans.status = 1'b1;
          end
        end
        pip_pkg::OP_QUERY: ans.in_poly = point_inside(x, y);
        default: ;
      endcase
      ans.held = vert_count[pip_pkg::HELD_W-1:0];
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function void check_result(logic in_poly, logic status,
                               logic [pip_pkg::HELD_W-1:0] held);
      answer_t want;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result inside=%0b st=%0b held=%0d",
                   $realtime, in_poly, status, held);
        return;
      end
      want = pending_answers.pop_front();
      if (want.in_poly !== in_poly || want.status !== status || want.held !== held) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp inside=%0b st=%0b held=%0d, got inside=%0b st=%0b held=%0d",
                   $realtime, want.in_poly, want.status, want.held, in_poly, status, held);
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [pip_pkg::OP_W-1:0]   in_operation = pip_pkg::OP_CLEAR;
  pip_pkg::coord_t            in_coord_x = '0;
  pip_pkg::coord_t            in_coord_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_inside_res;
  logic                       out_status;
  logic [pip_pkg::HELD_W-1:0] out_vertices_held;

  polygon_scoreboard sb = new();
  int              items_sent = 0;
  bit              quiet = 1'b0;
  pip_pkg::coord_t poly_x[$];
  pip_pkg::coord_t poly_y[$];

  point_in_polygon_test u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_inside_res    (out_inside_res),
    .out_status        (out_status),
    .out_vertices_held (out_vertices_held)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver stalls in bursts
  always begin
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_inside_res, out_status, out_vertices_held);
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [pip_pkg::OP_W-1:0] op, input pip_pkg::coord_t x,
                           input pip_pkg::coord_t y);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_coord_x   <= x;
    in_coord_y   <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, x, y);
    items_sent++;
    if (items_sent >= QUIET_AFTER) quiet = 1'b1;
    @(negedge clk);
  endtask

  task automatic clear_poly();
    send_item(pip_pkg::OP_CLEAR, pip_pkg::coord_t'($urandom), pip_pkg::coord_t'($urandom));
    poly_x.delete();
    poly_y.delete();
  endtask

  task automatic add_vertex(input pip_pkg::coord_t x, input pip_pkg::coord_t y);
    send_item(pip_pkg::OP_APPEND, x, y);
    if (poly_x.size() < pip_pkg::MAX_VERTICES) begin
      poly_x.insert(poly_x.size(), x);
      poly_y.insert(poly_y.size(), y);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // 0: full range, 1: small window, 2: near the extremes
  function automatic pip_pkg::coord_t pick_coord(int mode);
    int v;
    case (mode)
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'($urandom_range(0, 127)) - 64;
      default: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return pip_pkg::coord_t'(v);
  endfunction

  initial begin
    int              mode, nv, nq, k;
    pip_pkg::coord_t qx, qy;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty, one and two vertices, extremes, horizontal edge, vertex rows
    clear_poly();
    send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd0);
    send_item(OP_UNUSED, -16'sd1, -16'sd1);
    add_vertex(-16'sd32768, -16'sd32768);
    send_item(pip_pkg::OP_QUERY, -16'sd32768, -16'sd32768);
    add_vertex(16'sd32767, -16'sd32768);
    send_item(pip_pkg::OP_QUERY, 16'sd0, -16'sd32768);
    add_vertex(16'sd0, 16'sd32767);
    send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd0);
    send_item(pip_pkg::OP_QUERY, -16'sd32768, 16'sd32767);
    send_item(pip_pkg::OP_QUERY, 16'sd32767, -16'sd32768);
    send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd32767);
    send_item(pip_pkg::OP_QUERY, -16'sd1, -16'sd32768);
    send_item(pip_pkg::OP_QUERY, 16'sd16383, 16'sd0);
    clear_poly();
    add_vertex(16'sd0, 16'sd0);
    add_vertex(16'sd0, 16'sd10);
    send_item(pip_pkg::OP_QUERY, -16'sd1, 16'sd5);
    send_item(OP_UNUSED, 16'sd32767, -16'sd32768);
    add_vertex(16'sd10, 16'sd10);
    send_item(pip_pkg::OP_QUERY, 16'sd5, 16'sd5);
    send_item(pip_pkg::OP_QUERY, 16'sd5, 16'sd10);
    clear_poly();
    wait_results_drained();

    while (items_sent < TOTAL_ITEMS) begin
      mode = ($urandom_range(0, 9) < 5) ? 1 : (($urandom_range(0, 3) == 0) ? 2 : 0);
      // occasionally skip the clear so appends pile up against a full store
      if ($urandom_range(0, 9) != 0) clear_poly();
      case ($urandom_range(0, 9))
        0:       nv = $urandom_range(0, 2);
        1:       nv = $urandom_range(17, 20);
        2, 3:    nv = $urandom_range(9, 16);
        default: nv = $urandom_range(3, 8);
      endcase
      for (k = 0; k < nv; k++) add_vertex(pick_coord(mode), pick_coord(mode));
      nq = $urandom_range(2, 8);
      for (k = 0; k < nq; k++) begin
        qx = pick_coord(mode);
        qy = pick_coord(mode);
        // land on a vertex row or column to hit the half-open bounds
        if (poly_y.size() != 0 && $urandom_range(0, 2) == 0) begin
          qy = poly_y[$urandom_range(0, poly_y.size() - 1)];
          if ($urandom_range(0, 1) == 0) qx = poly_x[$urandom_range(0, poly_x.size() - 1)];
        end
        send_item(pip_pkg::OP_QUERY, qx, qy);
      end
      if ($urandom_range(0, 15) == 0)
        send_item(OP_UNUSED, pip_pkg::coord_t'($urandom), pip_pkg::coord_t'($urandom));
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(pip_pkg::OP_W'($urandom_range(0, 3)), pip_pkg::coord_t'($urandom),
                    pip_pkg::coord_t'($urandom));
        poly_x.delete();
        poly_y.delete();
        clear_poly();
      end
      if ($urandom_range(0, 39) == 0) wait_results_drained();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
